// ===== rtl/euq_pkg.sv =====
// Shared types, constants and arithmetic helpers for the Euler angle to
// quaternion converter. No dependencies.
package euq_pkg;

    localparam int CORDIC_STAGES = 14;
    localparam int ATAN_ENTRIES  = 24;
    localparam int NUM_CELLS     = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES
                                                                  : ATAN_ENTRIES;
    localparam int IDX_W         = 5;

    localparam logic signed [31:0] Q28_PI       = 32'sd843314857;
    localparam logic signed [31:0] Q28_HALF_PI  = 32'sd421657428;
    localparam logic signed [31:0] Q28_GAIN     = 32'sd163008218;
    localparam logic signed [63:0] Q28_HALF_LSB = 64'sd134217728;
    localparam logic signed [32:0] Q14_HALF_LSB = 33'sd8192;
    localparam logic signed [18:0] Q14_ONE      = 19'sd16384;

    // One angle's rotation state as it travels down the chain.
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               flip;
    } ang_t;

    // Roll, pitch and yaw, in that order from index 0.
    typedef ang_t [2:0] trio_t;

    function automatic logic signed [31:0] atan_q28(input logic [IDX_W-1:0] idx);
        logic signed [31:0] r;
        unique case (idx)
            5'd0:    r = 32'sd210828714;
            5'd1:    r = 32'sd124459457;
            5'd2:    r = 32'sd65760959;
            5'd3:    r = 32'sd33381290;
            5'd4:    r = 32'sd16755422;
            5'd5:    r = 32'sd8385879;
            5'd6:    r = 32'sd4193963;
            5'd7:    r = 32'sd2097109;
            5'd8:    r = 32'sd1048571;
            5'd9:    r = 32'sd524287;
            5'd10:   r = 32'sd262144;
            5'd11:   r = 32'sd131072;
            5'd12:   r = 32'sd65536;
            5'd13:   r = 32'sd32768;
            5'd14:   r = 32'sd16384;
            5'd15:   r = 32'sd8192;
            5'd16:   r = 32'sd4096;
            5'd17:   r = 32'sd2048;
            5'd18:   r = 32'sd1024;
            5'd19:   r = 32'sd512;
            5'd20:   r = 32'sd256;
            5'd21:   r = 32'sd128;
            5'd22:   r = 32'sd64;
            5'd23:   r = 32'sd32;
            default: r = 32'sd0;
        endcase
        return r;
    endfunction

    // Q.28 product, rounded half up with a floor shift.
    function automatic logic signed [31:0] mul_q28(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [63:0] p;
        p = (64'(a) * 64'(b)) + Q28_HALF_LSB;
        return p[59:28];
    endfunction

    // Q.28 to Q1.14 with rounding and clamping to plus or minus one.
    function automatic logic signed [15:0] to_q14(input logic signed [31:0] v);
        logic signed [32:0] t;
        logic signed [18:0] r;
        logic signed [18:0] c;
        t = 33'(v) + Q14_HALF_LSB;
        r = t[32:14];
        if (r > Q14_ONE) begin
            c = Q14_ONE;
        end else if (r < -Q14_ONE) begin
            c = -Q14_ONE;
        end else begin
            c = r;
        end
        return c[15:0];
    endfunction

endpackage

// ===== rtl/euq_cordic_cell.sv =====
// One rotation-mode CORDIC step for all three angles, with its own
// pipeline register and valid/ready handshake. Depends on euq_pkg.
module euq_cordic_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [euq_pkg::IDX_W-1:0]     stage_idx,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  euq_pkg::trio_t                in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output euq_pkg::trio_t                out_data
);

    logic           valid_reg;
    euq_pkg::trio_t data_reg;
    euq_pkg::trio_t data_next;
    logic signed [31:0] atan_val;

    assign atan_val = euq_pkg::atan_q28(stage_idx);
    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        for (int k = 0; k < 3; k++) begin
            dx = in_data[k].y >>> stage_idx;
            dy = in_data[k].x >>> stage_idx;
            data_next[k].flip = in_data[k].flip;
            if (!in_data[k].z[31]) begin
                data_next[k].x = in_data[k].x - dx;
                data_next[k].y = in_data[k].y + dy;
                data_next[k].z = in_data[k].z - atan_val;
            end else begin
                data_next[k].x = in_data[k].x + dx;
                data_next[k].y = in_data[k].y - dy;
                data_next[k].z = in_data[k].z + atan_val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/euq_combine.sv =====
// Sign fix-up, triple products, rounding and clamping: four pipeline
// stages after the CORDIC chain. Depends on euq_pkg.
module euq_combine (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  euq_pkg::trio_t     in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] quat_w,
    output logic signed [15:0] quat_x,
    output logic signed [15:0] quat_y,
    output logic signed [15:0] quat_z
);

    logic [3:0] valid_reg;
    logic [4:0] rdy;

    // Stage A: sines and cosines with the half-turn sign applied.
    logic signed [31:0] s_reg [3];
    logic signed [31:0] c_reg [3];
    // Stage B: pair products, yaw terms carried along.
    logic signed [31:0] cc_reg, ss_reg, sc_reg, cs_reg, sy_reg, cy_reg;
    // Stage C: the eight triple products.
    logic signed [31:0] p_reg [8];
    // Stage D: result registers.
    logic signed [15:0] w_reg, x_reg, y_reg, z_reg;

    always_comb begin
        rdy[4] = out_ready;
        for (int k = 3; k >= 0; k--) begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end
    assign in_ready = rdy[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (rdy[0]) valid_reg[0] <= in_valid;
            for (int k = 1; k < 4; k++) begin
                if (rdy[k]) valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0] && in_valid) begin
            for (int k = 0; k < 3; k++) begin
                s_reg[k] <= in_data[k].flip ? -in_data[k].y : in_data[k].y;
                c_reg[k] <= in_data[k].flip ? -in_data[k].x : in_data[k].x;
            end
        end
        if (rdy[1] && valid_reg[0]) begin
            cc_reg <= euq_pkg::mul_q28(c_reg[0], c_reg[1]);
            ss_reg <= euq_pkg::mul_q28(s_reg[0], s_reg[1]);
            sc_reg <= euq_pkg::mul_q28(s_reg[0], c_reg[1]);
            cs_reg <= euq_pkg::mul_q28(c_reg[0], s_reg[1]);
            sy_reg <= s_reg[2];
            cy_reg <= c_reg[2];
        end
        if (rdy[2] && valid_reg[1]) begin
            p_reg[0] <= euq_pkg::mul_q28(cc_reg, cy_reg);
            p_reg[1] <= euq_pkg::mul_q28(ss_reg, sy_reg);
            p_reg[2] <= euq_pkg::mul_q28(sc_reg, cy_reg);
            p_reg[3] <= euq_pkg::mul_q28(cs_reg, sy_reg);
            p_reg[4] <= euq_pkg::mul_q28(cs_reg, cy_reg);
            p_reg[5] <= euq_pkg::mul_q28(sc_reg, sy_reg);
            p_reg[6] <= euq_pkg::mul_q28(cc_reg, sy_reg);
            p_reg[7] <= euq_pkg::mul_q28(ss_reg, cy_reg);
        end
        if (rdy[3] && valid_reg[2]) begin
            w_reg <= euq_pkg::to_q14(p_reg[0] + p_reg[1]);
            x_reg <= euq_pkg::to_q14(p_reg[2] - p_reg[3]);
            y_reg <= euq_pkg::to_q14(p_reg[4] + p_reg[5]);
            z_reg <= euq_pkg::to_q14(p_reg[6] - p_reg[7]);
        end
    end

    assign out_valid = valid_reg[3];
    assign quat_w    = w_reg;
    assign quat_x    = x_reg;
    assign quat_y    = y_reg;
    assign quat_z    = z_reg;

endmodule

// ===== rtl/euler_to_quaternion_core.sv =====
// Top level of the Euler angle (ZYX) to quaternion converter.
// Depends on euq_pkg, euq_cordic_cell and euq_combine.
//
// Usage:
//   The input channel (s_valid/s_ready) carries one transaction of roll,
//   pitch and yaw angles in radians, signed Q3.12. The output channel
//   (m_valid/m_ready) carries one transaction of the quaternion w, x, y, z
//   in signed Q1.14, each clamped to plus or minus one.
//   Every input transaction produces exactly one output transaction, in
//   order. The block keeps no state between transactions.
//   The pipeline has one register per CORDIC cell, then four stages for
//   sign fix-up, pair products, triple products and final rounding.
//   It takes one transaction per cycle while m_ready stays high; every
//   stage is a register with its own valid bit, and the cell chain is what
//   sets the depth.
//   When the receiver stalls, results pile up stage by stage; bubbles are
//   squeezed out, so s_ready stays high until every stage holds a result.
//   Synchronous active-low reset clears all valid bits; data registers are
//   not reset.
module euler_to_quaternion_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_roll_angle,
    input  logic signed [15:0] s_pitch_angle,
    input  logic signed [15:0] s_yaw_angle,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_quat_w,
    output logic signed [15:0] m_quat_x,
    output logic signed [15:0] m_quat_y,
    output logic signed [15:0] m_quat_z
);

    localparam int N = euq_pkg::NUM_CELLS;

    logic           cv   [N+1];
    logic           crdy [N+1];
    euq_pkg::trio_t cd   [N+1];

    // Halve each angle into Q.28 and fold it into [-pi/2, pi/2]. A folded
    // angle has its sine and cosine negated after the CORDIC.
    always_comb begin
        logic signed [15:0] a [3];
        logic signed [31:0] z;
        a[0] = s_roll_angle;
        a[1] = s_pitch_angle;
        a[2] = s_yaw_angle;
        for (int k = 0; k < 3; k++) begin
            z = {a[k][15], a[k], 15'b0};
            cd[0][k].x = euq_pkg::Q28_GAIN;
            cd[0][k].y = '0;
            if (z > euq_pkg::Q28_HALF_PI) begin
                cd[0][k].z    = z - euq_pkg::Q28_PI;
                cd[0][k].flip = 1'b1;
            end else if (z < -euq_pkg::Q28_HALF_PI) begin
                cd[0][k].z    = z + euq_pkg::Q28_PI;
                cd[0][k].flip = 1'b1;
            end else begin
                cd[0][k].z    = z;
                cd[0][k].flip = 1'b0;
            end
        end
    end

    assign cv[0]   = s_valid;
    assign s_ready = crdy[0];

    // The CORDIC chain: cell k applies rotation step k to all three angles.
    for (genvar k = 0; k < N; k++) begin : g_cell
        euq_cordic_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .stage_idx (euq_pkg::IDX_W'(k)),
            .in_valid  (cv[k]),
            .in_ready  (crdy[k]),
            .in_data   (cd[k]),
            .out_valid (cv[k+1]),
            .out_ready (crdy[k+1]),
            .out_data  (cd[k+1])
        );
    end

    euq_combine u_combine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cv[N]),
        .in_ready  (crdy[N]),
        .in_data   (cd[N]),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .quat_w    (m_quat_w),
        .quat_x    (m_quat_x),
        .quat_y    (m_quat_y),
        .quat_z    (m_quat_z)
    );

    // An empty output stage means every stage can move, so input is taken.
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("s_ready low while output stage empty");

    a_wx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_quat_w <= 16'sd16384 && m_quat_w >= -16'sd16384 &&
                     m_quat_x <= 16'sd16384 && m_quat_x >= -16'sd16384))
        else $error("w or x outside clamp range");

    a_yz_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_quat_y <= 16'sd16384 && m_quat_y >= -16'sd16384 &&
                     m_quat_z <= 16'sd16384 && m_quat_z >= -16'sd16384))
        else $error("y or z outside clamp range");

endmodule

// ===== verif/euq_scoreboard.sv =====
// Checker for the Euler angle to quaternion converter: watches both channels,
// predicts each quaternion from the accepted angles and compares field by field.
// Depends on euq_pkg for the CORDIC stage count.
module euq_scoreboard (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [15:0] s_roll_angle,
    input  logic signed [15:0] s_pitch_angle,
    input  logic signed [15:0] s_yaw_angle,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [15:0] m_quat_w,
    input  logic signed [15:0] m_quat_x,
    input  logic signed [15:0] m_quat_y,
    input  logic signed [15:0] m_quat_z,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint PI_Q28      = 843314857;
    localparam longint HALF_PI_Q28 = 421657428;
    localparam longint GAIN_Q28    = 163008218;
    localparam int     STEPS       = (euq_pkg::CORDIC_STAGES < 24) ? euq_pkg::CORDIC_STAGES : 24;

    typedef struct {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } quat_t;

    localparam longint ARCTAN_Q28 [24] = '{
        210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
        4193963, 2097109, 1048571, 524287, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048,
        1024, 512, 256, 128, 64, 32
    };

    quat_t quat_queue[$];

    // Sine and cosine of half the angle, in Q.28, by rotation-mode CORDIC.
    function automatic void half_angle_sincos(input logic signed [15:0] ang,
                                              output longint sn, output longint cs);
        longint zr;
        longint xr;
        longint yr;
        longint dx;
        longint dy;
        bit     mirrored;
        zr = longint'(ang) * 32768;
        xr = GAIN_Q28;
        yr = 0;
        mirrored = 0;
        // Fold the half angle back into the CORDIC convergence range.
        if (zr > HALF_PI_Q28) begin
            zr -= PI_Q28;
            mirrored = 1;
        end else if (zr < -HALF_PI_Q28) begin
            zr += PI_Q28;
            mirrored = 1;
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = yr >>> i;
            dy = xr >>> i;
            if (zr >= 0) begin
                xr -= dx;
                yr += dy;
                zr -= ARCTAN_Q28[i];
            end else begin
                xr += dx;
                yr -= dy;
                zr += ARCTAN_Q28[i];
            end
        end
        sn = mirrored ? -yr : yr;
        cs = mirrored ? -xr : xr;
    endfunction

    function automatic longint q28_product(input longint a, input longint b);
        return (a * b + 64'sd134217728) >>> 28;
    endfunction

    function automatic logic signed [15:0] q14_clamped(input longint v);
        longint r;
        r = (v + 8192) >>> 14;
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return 16'(r);
    endfunction

    function automatic quat_t zyx_quaternion(input logic signed [15:0] roll,
                                             input logic signed [15:0] pitch,
                                             input logic signed [15:0] yaw);
        longint sr, cr, sp, cp, sy, cy;
        longint cc, ss, sc, cs;
        quat_t  q;
        half_angle_sincos(roll, sr, cr);
        half_angle_sincos(pitch, sp, cp);
        half_angle_sincos(yaw, sy, cy);
        cc = q28_product(cr, cp);
        ss = q28_product(sr, sp);
        sc = q28_product(sr, cp);
        cs = q28_product(cr, sp);
        q.w = q14_clamped(q28_product(cc, cy) + q28_product(ss, sy));
        q.x = q14_clamped(q28_product(sc, cy) - q28_product(cs, sy));
        q.y = q14_clamped(q28_product(cs, cy) + q28_product(sc, sy));
        q.z = q14_clamped(q28_product(cc, sy) - q28_product(ss, cy));
        return q;
    endfunction

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge aclk) begin
        quat_t expd;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                quat_queue.push_back(zyx_quaternion(s_roll_angle, s_pitch_angle, s_yaw_angle));
            end
            if (m_valid && m_ready) begin
                if (quat_queue.size() == 0) begin
                    $error("unexpected result transaction w=%0d x=%0d y=%0d z=%0d",
                           m_quat_w, m_quat_x, m_quat_y, m_quat_z);
                    fail_count++;
                end else begin
                    expd = quat_queue.pop_front();
                    if (m_quat_w !== expd.w) begin
                        $error("quat_w expected %0d actual %0d", expd.w, m_quat_w);
                        fail_count++;
                    end
                    if (m_quat_x !== expd.x) begin
                        $error("quat_x expected %0d actual %0d", expd.x, m_quat_x);
                        fail_count++;
                    end
                    if (m_quat_y !== expd.y) begin
                        $error("quat_y expected %0d actual %0d", expd.y, m_quat_y);
                        fail_count++;
                    end
                    if (m_quat_z !== expd.z) begin
                        $error("quat_z expected %0d actual %0d", expd.z, m_quat_z);
                        fail_count++;
                    end
                end
            end
            pending = quat_queue.size();
        end
    end

endmodule

// ===== verif/euler_to_quaternion_core_tb.sv =====
// Top of the testbench for euler_to_quaternion_core: clock, reset, angle
// stimulus, random output stalls and the verdict. Depends on euq_scoreboard.
module euler_to_quaternion_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 900;
    localparam int CALM_TAIL    = 150;   // Last transactions run with no idling.
    localparam int DRAIN_CYCLES = 40;    // Well past the pipeline latency.

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_roll_angle = '0;
    logic signed [15:0] s_pitch_angle = '0;
    logic signed [15:0] s_yaw_angle = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_quat_w, m_quat_x, m_quat_y, m_quat_z;
    int                 fail_count;
    int                 pending;
    bit                 calm = 1'b0;
    int                 stall_left = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    euler_to_quaternion_core dut (
        .aclk, .aresetn, .s_valid, .s_ready,
        .s_roll_angle, .s_pitch_angle, .s_yaw_angle,
        .m_valid, .m_ready, .m_quat_w, .m_quat_x, .m_quat_y, .m_quat_z
    );

    euq_scoreboard checker_inst (
        .aclk, .aresetn, .s_valid, .s_ready,
        .s_roll_angle, .s_pitch_angle, .s_yaw_angle,
        .m_valid, .m_ready, .m_quat_w, .m_quat_x, .m_quat_y, .m_quat_z,
        .fail_count, .pending
    );

    // The receiver stalls in random bursts until the calm tail of the run,
    // where it takes every result at once.
    always @(posedge aclk) begin
        if (calm) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Presents one transaction and returns on the rising edge that accepts it.
    // s_ready only moves at a rising edge, so it is sampled at the falling edge
    // before the candidate edge; the next drive then lands on the accept edge.
    task automatic send_angles(input logic signed [15:0] roll,
                               input logic signed [15:0] pitch,
                               input logic signed [15:0] yaw);
        bit taken;
        int gap;
        // A random sender gap, occasionally, outside the calm tail.
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_roll_angle  <= roll;
        s_pitch_angle <= pitch;
        s_yaw_angle   <= yaw;
        taken = 1'b0;
        while (!taken) begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end
    endtask

    // Half the angles are full-range; the rest stay near zero or near the half-angle
    // fold at plus or minus pi, where the CORDIC result is mirrored.
    function automatic logic signed [15:0] pick_angle();
        logic signed [15:0] a;
        case ($urandom_range(0, 3))
            0:       a = 16'($urandom_range(0, 255)) - 16'sd128;
            1:       a = ($urandom_range(0, 1) ? 16'sd12868 : -16'sd12868)
                         + 16'($urandom_range(0, 8)) - 16'sd4;
            default: a = 16'($urandom());
        endcase
        return a;
    endfunction

    initial begin
        // Half angles just inside and outside pi/2 sit at 12867 and 12868.
        logic signed [15:0] corner [10] = '{
            16'sd0, 16'sd1, -16'sd1, 16'sd32767, -16'sd32768,
            16'sd12867, 16'sd12868, -16'sd12867, -16'sd12868, 16'sd6434
        };
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: each corner value on roll and on pitch, the yaw extremes, then all three together.
        foreach (corner[i]) send_angles(corner[i], 16'sd0, 16'sd0);
        foreach (corner[i]) send_angles(16'sd0, corner[i], 16'sd0);
        send_angles(16'sd0, 16'sd0, 16'sd32767);
        send_angles(16'sd0, 16'sd0, -16'sd32768);
        send_angles(16'sd12868, -16'sd12868, 16'sd12867);
        send_angles(16'sd32767, 16'sd32767, 16'sd32767);
        send_angles(-16'sd32768, -16'sd32768, -16'sd32768);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - CALM_TAIL) calm = 1'b1;
            send_angles(pick_angle(), pick_angle(), pick_angle());
        end
        s_valid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Guard against a hung handshake; a correct run needs well under a tenth of this.
    initial begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
